FILE: rtl/bpl_pkg.sv
// ---------------------------------------------------------------------------
// bpl_pkg - shared types and constants of the brace property list parser
// Holds the parser state, result item layout, character codes and the
// sizing of the result queue.
// ---------------------------------------------------------------------------
package bpl_pkg;

	// deepest brace nesting allowed inside a value
	localparam int MAX_NESTING = 255;
	localparam int NEST_W      = $clog2(MAX_NESTING + 1);

	// result queue, one entry per input beat that gives results
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CHAR_W   = 16;
	localparam int STATUS_W = 3;
	localparam int KIND_W   = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	// character codes
	localparam logic [CHAR_W-1:0] CH_COLON = 16'h003A;
	localparam logic [CHAR_W-1:0] CH_OPEN  = 16'h007B;
	localparam logic [CHAR_W-1:0] CH_CLOSE = 16'h007D;
	localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
	localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
	localparam logic [CHAR_W-1:0] CH_GFIRST = 16'h0021;
	localparam logic [CHAR_W-1:0] CH_GLAST  = 16'h007E;

	typedef enum logic [1:0] {
		PH_BETWEEN     = 2'd0,
		PH_NAME        = 2'd1,
		PH_AFTER_COLON = 2'd2,
		PH_VALUE       = 2'd3
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		K_NAME  = 2'd0,
		K_VALUE = 2'd1,
		K_ENTRY = 2'd2,
		K_DONE  = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_NO_COLON   = 3'd1,
		ST_NO_OPEN    = 3'd2,
		ST_UNCLOSED   = 3'd3,
		ST_TOO_DEEP   = 3'd4
	} status_t;

	typedef struct packed {
		phase_t              phase;
		logic [NEST_W-1:0]   nesting;
		logic                failed;
	} parse_state_t;

	typedef struct packed {
		kind_t               kind;
		logic [CHAR_W-1:0]   ch;
		status_t             status;
	} result_t;

	// one queue entry: first result, second result, second one present
	typedef struct packed {
		result_t r0;
		result_t r1;
		logic    pair;
	} res_entry_t;

	localparam parse_state_t STATE_RESET = '{phase: PH_BETWEEN, nesting: '0, failed: 1'b0};

endpackage

FILE: rtl/brace_property_list_parser.sv
// ---------------------------------------------------------------------------
// brace_property_list_parser - streaming parser for name:{value} text
// Takes one 16-bit code unit per beat, gives name characters, value
// characters, entry-complete markers and a final status.
// ---------------------------------------------------------------------------
// Input channel s_*: one code unit per beat in s_tdata, s_tlast on the last
// unit of the text. Output channel m_*: one result per beat, m_tuser holds
// the kind, m_tdata the character and status, m_tlast the last result
// caused by one input beat. A beat gives zero, one or two results.
// An accepted beat is registered in the input register, parsed and its
// results written into the result queue, which offers them on m_*.
// Throughput: one input beat per cycle while the receiver keeps up; a beat
// with two results holds the output for both of them, so the rate is set
// by the single output port and the four-group result queue.
// s_tready drops when the queue plus the beat in the input register would
// fill it, so a stalled receiver holds the input back without loss.
// Reset empties the queue and the input register and puts the parser
// between entries with zero nesting and no error pending.
// ---------------------------------------------------------------------------
module brace_property_list_parser import bpl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] code_unit
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] char_out, [18:16] status, rest zero
	output logic [KIND_W-1:0]     m_tuser,   // [1:0] kind
	output logic                  m_tlast
);

	logic                valid_s1;
	logic [CHAR_W-1:0]   unit_s1;
	logic                last_s1;
	parse_state_t        state_q;
	parse_state_t        state_nxt;
	logic [1:0]          res_cnt;
	result_t             res0;
	result_t             res1;
	res_entry_t          wr_entry;
	logic                wr_en;
	logic [QCNT_W-1:0]   q_count;
	result_t             out_res;

	// room for the beat in the input register and one more
	assign s_tready = ({1'b0, q_count} + (QCNT_W + 1)'(valid_s1)) < (QCNT_W + 1)'(QUEUE_DEPTH);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			unit_s1 <= s_tdata[CHAR_W-1:0];
			last_s1 <= s_tlast;
		end
	end

	bpl_step u_step (
		.st         (state_q),
		.code_unit  (unit_s1),
		.final_unit (last_s1),
		.nxt        (state_nxt),
		.res_cnt    (res_cnt),
		.res0       (res0),
		.res1       (res1)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (valid_s1) begin
			state_q <= state_nxt;
		end
	end

	// queue write of the results of one beat
	assign wr_en    = valid_s1 && res_cnt != 2'd0;
	assign wr_entry = '{r0: res0, r1: res1, pair: res_cnt == 2'd2};

	bpl_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_entry  (wr_entry),
		.count     (q_count),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res),
		.out_last  (m_tlast)
	);

	// output packing
	assign m_tdata = {{(OUT_DATA_W - CHAR_W - STATUS_W){1'b0}}, out_res.status, out_res.ch};
	assign m_tuser = out_res.kind;

	// the queue never overflows when a beat writes its results
	a_no_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> q_count < QCNT_W'(QUEUE_DEPTH))
		else $error("result queue written while full");

	// the last unit of a text always leaves the parser in its reset state
	a_final_resets : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> (state_q.phase == PH_BETWEEN && state_q.nesting == '0
			&& !state_q.failed))
		else $error("parser not back to reset after the last unit");

	// nesting is only non-zero inside a value
	a_nest_in_value : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase != PH_VALUE) |-> (state_q.nesting == '0))
		else $error("nesting left over outside a value");

	// no results once an error is pending
	a_quiet_after_error : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && state_q.failed) |-> !wr_en)
		else $error("result given after an error");

endmodule

FILE: rtl/bpl_step.sv
// ---------------------------------------------------------------------------
// bpl_step - parser update for one code unit
// Works out the next parser state and up to two result items from the
// current state and one registered input beat.
// ---------------------------------------------------------------------------
module bpl_step import bpl_pkg::*; (
	input  parse_state_t       st,
	input  logic [CHAR_W-1:0]  code_unit,
	input  logic               final_unit,
	output parse_state_t       nxt,
	output logic [1:0]         res_cnt,
	output result_t            res0,
	output result_t            res1
);

	logic    is_space;
	logic    is_graphic;
	logic    prim_v;
	result_t prim;
	logic    done_v;
	result_t done_r;
	logic [NEST_W-1:0] nest_dec;

	// character classes
	assign is_space   = (code_unit >= CH_TAB && code_unit <= CH_CR) || code_unit == CH_SPACE;
	assign is_graphic = code_unit >= CH_GFIRST && code_unit <= CH_GLAST;
	assign nest_dec   = (st.nesting != '0) ? st.nesting - 1'b1 : '0;

	// phase update and the result caused by the unit itself
	always_comb begin
		nxt    = st;
		prim_v = 1'b0;
		prim   = '{kind: K_VALUE, ch: code_unit, status: ST_OK};
		done_v = 1'b0;
		done_r = '{kind: K_DONE, ch: '0, status: ST_OK};
		if (!st.failed) begin
			unique case (st.phase)
				PH_BETWEEN: begin
					if (is_space) begin
						nxt.phase = PH_BETWEEN;
					end else if (code_unit == CH_COLON) begin
						nxt.phase = PH_AFTER_COLON;
					end else begin
						nxt.phase = PH_NAME;
						prim_v    = is_graphic;
						prim.kind = K_NAME;
					end
				end
				PH_NAME: begin
					if (code_unit == CH_COLON) begin
						nxt.phase = PH_AFTER_COLON;
					end else begin
						prim_v    = is_graphic;
						prim.kind = K_NAME;
					end
				end
				PH_AFTER_COLON: begin
					if (code_unit == CH_OPEN) begin
						nxt.phase   = PH_VALUE;
						nxt.nesting = NEST_W'(1);
					end else if (!is_space) begin
						prim_v     = 1'b1;
						prim       = '{kind: K_DONE, ch: '0, status: ST_NO_OPEN};
						nxt.failed = 1'b1;
					end
				end
				PH_VALUE: begin
					prim_v = 1'b1;
					if (code_unit == CH_OPEN) begin
						if (st.nesting >= NEST_W'(MAX_NESTING)) begin
							prim       = '{kind: K_DONE, ch: '0, status: ST_TOO_DEEP};
							nxt.failed = 1'b1;
						end else begin
							nxt.nesting = st.nesting + 1'b1;
						end
					end else if (code_unit == CH_CLOSE) begin
						nxt.nesting = nest_dec;
						if (nest_dec == '0) begin
							prim      = '{kind: K_ENTRY, ch: '0, status: ST_OK};
							nxt.phase = PH_BETWEEN;
						end
					end
				end
			endcase
		end

		// end of text: final status unless an error was already given
		if (final_unit) begin
			if (!nxt.failed) begin
				done_v = 1'b1;
				unique case (nxt.phase)
					PH_NAME:        done_r.status = ST_NO_COLON;
					PH_AFTER_COLON: done_r.status = ST_NO_OPEN;
					PH_VALUE:       done_r.status = ST_UNCLOSED;
					PH_BETWEEN:     done_r.status = ST_OK;
				endcase
			end
			nxt = STATE_RESET;
		end
	end

	// pack the results in order
	always_comb begin
		res_cnt = {1'b0, prim_v} + {1'b0, done_v};
		res0    = prim_v ? prim : done_r;
		res1    = done_r;
	end

endmodule

FILE: rtl/bpl_res_queue.sv
// ---------------------------------------------------------------------------
// bpl_res_queue - result queue and output serialiser
// Holds up to QUEUE_DEPTH groups of one or two results and hands them out
// one beat at a time, marking the last beat of each group.
// ---------------------------------------------------------------------------
module bpl_res_queue import bpl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  res_entry_t        wr_entry,
	output logic [QCNT_W-1:0] count,
	output logic              out_valid,
	input  logic              out_ready,
	output result_t           out_res,
	output logic              out_last
);

	res_entry_t          entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                sub_q;
	res_entry_t          head;
	logic                beat;
	logic                pop;

	// head selection
	assign head      = entries_q[rd_ptr_q];
	assign out_valid = count_q != '0;
	assign out_res   = sub_q ? head.r1 : head.r0;
	assign out_last  = sub_q || !head.pair;
	assign beat      = out_valid && out_ready;
	assign pop       = beat && out_last;
	assign count     = count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

	// pointers, fill count and position inside the group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sub_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (beat) begin
				sub_q <= !out_last;
			end
			count_q <= count_q + QCNT_W'(wr_en) - QCNT_W'(pop);
		end
	end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - self-checking bench for the brace property list parser
// Feeds short hand-picked texts, then random name:{value} texts with some
// damage, noise and two deep nesting runs. Every accepted code unit goes
// through a behavioural parser model that queues the results it expects;
// each output beat is compared field by field against the oldest of them.
// Both sides idle at random, and once the output holds off for a long time.
// ---------------------------------------------------------------------------
module testbench import bpl_pkg::*; ();

	localparam int PERIOD       = 12;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 120;
	localparam int UNITS_TARGET = 1150;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // [15:0] code_unit
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // [15:0] char_out, [18:16] status, rest zero
	logic [KIND_W-1:0]     m_tuser;   // [1:0] kind
	logic                  m_tlast;

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] ch;
		status_t           status;
		logic              run_last;
	} parse_result_t;

	// behavioural parser and the results it still waits for
	class parse_scoreboard;
		phase_t          phase;
		int unsigned     depth;
		bit              failed;
		parse_result_t   expected_results[$];
		int              mismatches;

		function new();
			mismatches = 0;
			reset_parser();
		endfunction

		function void reset_parser();
			phase  = PH_BETWEEN;
			depth  = 0;
			failed = 1'b0;
		endfunction

		function bit is_space(logic [CHAR_W-1:0] cu);
			return (cu >= CH_TAB && cu <= CH_CR) || cu == CH_SPACE;
		endfunction

		function bit is_graphic(logic [CHAR_W-1:0] cu);
			return cu >= CH_GFIRST && cu <= CH_GLAST;
		endfunction

		function parse_result_t make_result(kind_t k, logic [CHAR_W-1:0] ch, status_t st);
			parse_result_t r;
			r.kind     = k;
			r.ch       = ch;
			r.status   = st;
			r.run_last = 1'b0;
			return r;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// one accepted input beat
		function void note_unit(logic [CHAR_W-1:0] cu, logic fin);
			parse_result_t outs[$];
			status_t       st;
			if (failed) begin
				if (fin)
					reset_parser();
				return;
			end
			case (phase)
				PH_BETWEEN: begin
					if (is_space(cu)) begin
					end else if (cu == CH_COLON) begin
						phase = PH_AFTER_COLON;
					end else begin
						phase = PH_NAME;
						if (is_graphic(cu))
							outs = {outs, make_result(K_NAME, cu, ST_OK)};
					end
				end
				PH_NAME: begin
					if (cu == CH_COLON)
						phase = PH_AFTER_COLON;
					else if (is_graphic(cu))
						outs = {outs, make_result(K_NAME, cu, ST_OK)};
				end
				PH_AFTER_COLON: begin
					if (cu == CH_OPEN) begin
						phase = PH_VALUE;
						depth = 1;
					end else if (!is_space(cu)) begin
						outs = {outs, make_result(K_DONE, '0, ST_NO_OPEN)};
						failed = 1'b1;
					end
				end
				default: begin
					if (cu == CH_OPEN) begin
						if (depth >= MAX_NESTING) begin
							outs = {outs, make_result(K_DONE, '0, ST_TOO_DEEP)};
							failed = 1'b1;
						end else begin
							depth++;
							outs = {outs, make_result(K_VALUE, cu, ST_OK)};
						end
					end else if (cu == CH_CLOSE) begin
						if (depth > 0)
							depth--;
						if (depth > 0) begin
							outs = {outs, make_result(K_VALUE, cu, ST_OK)};
						end else begin
							outs = {outs, make_result(K_ENTRY, '0, ST_OK)};
							phase = PH_BETWEEN;
						end
					end else begin
						outs = {outs, make_result(K_VALUE, cu, ST_OK)};
					end
				end
			endcase
			// end of text: final status unless an error was already given
			if (fin) begin
				if (!failed) begin
					case (phase)
						PH_NAME:        st = ST_NO_COLON;
						PH_AFTER_COLON: st = ST_NO_OPEN;
						PH_VALUE:       st = ST_UNCLOSED;
						default:        st = ST_OK;
					endcase
					outs = {outs, make_result(K_DONE, '0, st)};
				end
				reset_parser();
			end
			if (outs.size() > 0)
				outs[outs.size()-1].run_last = 1'b1;
			expected_results = {expected_results, outs};
		endfunction

		// one accepted output beat
		function void check_result(kind_t k, logic [CHAR_W-1:0] ch, logic [STATUS_W-1:0] st,
				logic lst, logic [4:0] pad);
			parse_result_t e;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none,", $time,
					" actual kind %0d char %h status %0d last %b", k, ch, st, lst);
				mismatches++;
				return;
			end
			e = expected_results.pop_front();
			if (k !== e.kind || ch !== e.ch || st !== e.status || lst !== e.run_last
					|| pad !== '0) begin
				$display("%0t: expected kind %0d char %h status %0d last %b,",
					$time, e.kind, e.ch, e.status, e.run_last,
					" actual kind %0d char %h status %0d last %b pad %h",
					k, ch, st, lst, pad);
				mismatches++;
			end
		endfunction
	endclass

	parse_scoreboard   board;
	logic [CHAR_W-1:0] text_units[$];
	int                units_sent = 0;
	int                burst_left = 0;
	int                stall_cycles = 0;

	// hand-picked texts, bit 16 marks the last unit
	logic [16:0] directed_units [26] = '{
		{1'b0, CH_SPACE}, {1'b0, CH_TAB}, {1'b0, 16'h0061}, {1'b0, 16'h0000},
		{1'b0, CH_COLON}, {1'b0, CH_CR}, {1'b0, CH_OPEN}, {1'b0, 16'hFFFF},
		{1'b0, CH_OPEN}, {1'b0, CH_CLOSE}, {1'b0, CH_CLOSE}, {1'b1, 16'h000A},
		// empty name, then a colon as the last unit
		{1'b0, CH_COLON}, {1'b0, CH_OPEN}, {1'b0, CH_CLOSE}, {1'b1, CH_COLON},
		// text ends in a name
		{1'b0, CH_GFIRST}, {1'b1, CH_GLAST},
		// wrong unit after the colon, rest absorbed
		{1'b0, 16'h006B}, {1'b0, CH_COLON}, {1'b0, 16'h0078}, {1'b1, 16'h007A},
		// text ends inside a value
		{1'b0, 16'h0076}, {1'b0, CH_COLON}, {1'b0, CH_OPEN}, {1'b1, 16'h0071}
	};

	brace_property_list_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #(PERIOD/2) clk = ~clk;

	// append one unit to the text being composed
	function automatic void add_unit(input logic [CHAR_W-1:0] cu);
		text_units = {text_units, cu};
	endfunction

	function automatic logic [CHAR_W-1:0] space_unit();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : CH_TAB + CHAR_W'(r);
	endfunction

	function automatic logic [CHAR_W-1:0] noise_unit();
		case ($urandom_range(0, 5))
			0:       return CH_COLON;
			1:       return CH_OPEN;
			2:       return CH_CLOSE;
			3:       return space_unit();
			default: return CHAR_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// one input beat, opening a new burst after a random gap when due
	task automatic send_unit(input logic [CHAR_W-1:0] cu, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tdata  = cu;
		s_tlast  = fin;
		do @(posedge clk); while (!s_tready);
		board.note_unit(cu, fin);
		units_sent++;
		@(negedge clk);
	endtask

	task automatic send_text();
		foreach (text_units[i])
			send_unit(text_units[i], i == text_units.size() - 1);
	endtask

	// mostly well-formed entries with random content, some damaged or pure noise
	task automatic compose_text();
		int          nest;
		int          r;
		int          cut;
		logic [CHAR_W-1:0] u;
		text_units.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) add_unit(noise_unit());
			return;
		end
		repeat ($urandom_range(1, 4)) begin
			repeat ($urandom_range(0, 2)) add_unit(space_unit());
			repeat ($urandom_range(0, 5)) begin
				if ($urandom_range(0, 4) == 0)
					u = CHAR_W'($urandom_range(0, 16'hFFFF));
				else
					u = CHAR_W'($urandom_range(CH_GFIRST, CH_GLAST));
				if (u == CH_COLON)
					u = 16'h006E;
				add_unit(u);
			end
			add_unit(CH_COLON);
			repeat ($urandom_range(0, 2)) add_unit(space_unit());
			add_unit(CH_OPEN);
			nest = 0;
			repeat ($urandom_range(0, 6)) begin
				r = $urandom_range(0, 9);
				if (r < 2 && nest < 4) begin
					add_unit(CH_OPEN);
					nest++;
				end else if (r < 4 && nest > 0) begin
					add_unit(CH_CLOSE);
					nest--;
				end else begin
					if (r < 7)
						u = CHAR_W'($urandom_range(0, 16'hFFFF));
					else
						u = CHAR_W'($urandom_range(CH_GFIRST, CH_GLAST));
					if (u == CH_OPEN || u == CH_CLOSE)
						u = 16'h0076;
					add_unit(u);
				end
			end
			repeat (nest) add_unit(CH_CLOSE);
			add_unit(CH_CLOSE);
		end
		repeat ($urandom_range(0, 2)) add_unit(space_unit());
		// damage: cut short or overwrite one unit
		r = $urandom_range(0, 7);
		if (r == 0) begin
			cut = $urandom_range(1, text_units.size());
			while (text_units.size() > cut)
				void'(text_units.pop_back());
		end else if (r == 1) begin
			text_units[$urandom_range(0, text_units.size() - 1)] = noise_unit();
		end
	endtask

	// value opened, then extra opening braces up to or past the nesting limit
	task automatic compose_deep_text(input int opens);
		text_units.delete();
		add_unit(16'h0064);
		add_unit(CH_COLON);
		add_unit(CH_OPEN);
		repeat (opens) add_unit(CH_OPEN);
		add_unit(CH_CLOSE);
		add_unit(16'h0078);
	endtask

	// reset, stimulus and final verdict
	initial begin : stimulus
		int text_count;
		board    = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_units[i])
			send_unit(directed_units[i][CHAR_W-1:0], directed_units[i][16]);

		text_count = 0;
		while (units_sent < UNITS_TARGET) begin
			if (text_count == 15)
				compose_deep_text(MAX_NESTING - 1);
			else if (text_count == 30)
				compose_deep_text(MAX_NESTING);
			else
				compose_text();
			send_text();
			text_count++;
		end
		s_tvalid = 1'b0;
		s_tlast  = 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("brace_property_list_parser: match");
		else
			$display("brace_property_list_parser: mismatch");
		$finish;
	end

	// receiver: changing ready patterns, one long hold-off while input keeps coming
	initial begin : receiver
		int pattern_sel;
		int span;
		int tick;
		bit held;
		held     = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			pattern_sel = $urandom_range(0, 3);
			span = $urandom_range(8, 48);
			for (tick = 0; tick < span; tick++) begin
				@(negedge clk);
				if (!held && units_sent >= HOLD_AT) begin
					held     = 1'b1;
					m_tready = 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				case (pattern_sel)
					0:       m_tready = 1'b1;
					1:       m_tready = ($urandom_range(0, 1) == 1);
					2:       m_tready = (tick % 4 == 0);
					default: m_tready = ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	// output beats into the scoreboard
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(kind_t'(m_tuser), m_tdata[15:0], m_tdata[18:16], m_tlast,
				m_tdata[23:19]);
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("brace_property_list_parser: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule

FILE: brace_property_list_parser.f
rtl/bpl_pkg.sv
rtl/bpl_step.sv
rtl/bpl_res_queue.sv
rtl/brace_property_list_parser.sv
tb/sv/testbench.sv
